>>> hw/rtl/double_tap_control_key_detector_assert.svh
// ----------------------------------------------------------------------------
// double tap detector assertion macros
// concurrent checks that can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef DOUBLE_TAP_CONTROL_KEY_DETECTOR_ASSERT_SVH
`define DOUBLE_TAP_CONTROL_KEY_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// check outside reset
`define DTCK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dtck assertion failed");
// check that also covers the reset cycles
`define DTCK_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dtck reset assertion failed");
`else
`define DTCK_ASSERT(label, prop)
`define DTCK_ASSERT_RST(label, prop)
`endif

`endif

>>> hw/rtl/dtck_pkg.sv
// ----------------------------------------------------------------------------
// dtck_pkg
// shared constants and types of the double tap control key detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtck_pkg;

  localparam int TIME_BITS = 32;
  localparam int IN_TIME_W = 32;
  localparam int CFG_W     = 16;

  // key codes
  localparam logic [1:0] KEY_OTHER = 2'd0;
  localparam logic [1:0] KEY_LEFT  = 2'd1;
  localparam logic [1:0] KEY_RIGHT = 2'd2;

  // side select codes
  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_EITHER = 2'd2;

  // command codes
  localparam logic CMD_KEY   = 1'b0;
  localparam logic CMD_MOUSE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SIDE     = 2'd0;
  localparam logic [1:0] REG_MIN      = 2'd1;
  localparam logic [1:0] REG_MAX      = 2'd2;
  localparam logic [1:0] REG_COOLDOWN = 2'd3;

  // register reset values
  localparam logic [1:0]       SIDE_RESET     = SIDE_EITHER;
  localparam logic [CFG_W-1:0] MIN_RESET      = 16'd50;
  localparam logic [CFG_W-1:0] MAX_RESET      = 16'd400;
  localparam logic [CFG_W-1:0] COOLDOWN_RESET = 16'd500;

  typedef struct packed {
    logic                 mouse_held;
    logic                 other_key_held;
    logic [IN_TIME_W-1:0] time_ms;
    logic                 is_repeat;
    logic                 is_press;
    logic [1:0]           key_code;
    logic                 command;
  } evt_t;

  typedef struct packed {
    logic [1:0]       side_select;
    logic [CFG_W-1:0] min_interval_ms;
    logic [CFG_W-1:0] max_interval_ms;
    logic [CFG_W-1:0] cool_period;
  } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/dtck_core.sv
// ----------------------------------------------------------------------------
// dtck_core
// tap state machine: phase, candidate key, first press time, cooldown end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_tap_control_key_detector_assert.svh"

module dtck_core
  import dtck_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic clear,
  input  wire logic step,
  input  wire evt_t ev,
  input  wire cfg_t cfg,
  output logic      tap
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DOWN = 2'd1;
  localparam logic [1:0] PH_UP   = 2'd2;
  localparam logic [1:0] PH_TRIG = 2'd3;

  logic [1:0]           phase;
  logic [1:0]           phase_next;
  logic [1:0]           candidate;
  logic [1:0]           candidate_next;
  logic [TIME_BITS-1:0] first_press_time;
  logic [TIME_BITS-1:0] first_press_time_next;
  logic [TIME_BITS-1:0] cooldown_end;
  logic [TIME_BITS-1:0] cooldown_end_next;

  logic [TIME_BITS-1:0] t;
  logic [TIME_BITS-1:0] gap;
  logic [TIME_BITS:0]   end_sum;
  logic [TIME_BITS-1:0] end_sat;
  logic                 key_ok;
  logic                 in_window;

  assign t       = TIME_BITS'(ev.time_ms);
  assign gap     = t - first_press_time;
  assign end_sum = {1'b0, t} + (TIME_BITS + 1)'(cfg.cool_period);
  assign end_sat = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];

  assign key_ok = ((ev.key_code == KEY_LEFT) &&
                   ((cfg.side_select == SIDE_LEFT) || (cfg.side_select == SIDE_EITHER))) ||
                  ((ev.key_code == KEY_RIGHT) &&
                   ((cfg.side_select == SIDE_RIGHT) || (cfg.side_select == SIDE_EITHER)));

  assign in_window = (gap >= TIME_BITS'(cfg.min_interval_ms)) &&
                     (gap <= TIME_BITS'(cfg.max_interval_ms));

  always_comb begin
    phase_next            = phase;
    candidate_next        = candidate;
    first_press_time_next = first_press_time;
    cooldown_end_next     = cooldown_end;
    tap                   = 1'b0;
    if ((ev.command == CMD_MOUSE) || !key_ok) begin
      phase_next            = PH_IDLE;
      candidate_next        = KEY_OTHER;
      first_press_time_next = '0;
    end else if (ev.is_repeat) begin
      // autorepeat leaves everything as is
    end else if (ev.other_key_held || ev.mouse_held || (t < cooldown_end)) begin
      phase_next            = PH_IDLE;
      candidate_next        = KEY_OTHER;
      first_press_time_next = '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (ev.is_press) begin
            phase_next            = PH_DOWN;
            candidate_next        = ev.key_code;
            first_press_time_next = t;
          end
        end
        PH_DOWN: begin
          if (ev.key_code != candidate) begin
            phase_next            = PH_IDLE;
            candidate_next        = KEY_OTHER;
            first_press_time_next = '0;
          end else if (!ev.is_press) begin
            phase_next = PH_UP;
          end
        end
        PH_UP: begin
          if (ev.is_press) begin
            if ((ev.key_code == candidate) && in_window) begin
              phase_next        = PH_TRIG;
              cooldown_end_next = end_sat;
              tap               = 1'b1;
            end else begin
              phase_next            = PH_DOWN;
              candidate_next        = ev.key_code;
              first_press_time_next = t;
            end
          end
        end
        default: begin
          if ((ev.key_code == candidate) && !ev.is_press) begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase            <= PH_IDLE;
      candidate        <= KEY_OTHER;
      first_press_time <= '0;
      cooldown_end     <= '0;
    end else if (step) begin
      phase            <= phase_next;
      candidate        <= candidate_next;
      first_press_time <= first_press_time_next;
      cooldown_end     <= cooldown_end_next;
    end
  end

  `DTCK_ASSERT_RST(a_reset_idle, rst |=> (phase == PH_IDLE) && (candidate == KEY_OTHER))
  `DTCK_ASSERT(a_tap_from_up, (step && tap && !clear) |=> (phase == PH_TRIG))
  `DTCK_ASSERT(a_tap_needs_up, tap |-> (phase == PH_UP))
  `DTCK_ASSERT(a_cand_valid, (phase != PH_IDLE) |-> (candidate[1] ^ candidate[0]))
  `DTCK_ASSERT(a_cooldown_hold, (!rst && !clear && !(step && tap)) |=> $stable(cooldown_end))

endmodule

`default_nettype wire

>>> hw/rtl/double_tap_control_key_detector.sv
// path: an accepted item is held in the input register, then in the result register
// throughput: one item per cycle while the result is not stalled; the tap state updates once per item
// a stalled result register holds one item while the input register takes the next
// reset: synchronous active high rst clears state and both stages, loads register defaults
// a config write also clears the tap state, keeping the other registers
// ----------------------------------------------------------------------------
// double_tap_control_key_detector
// detects a double tap of a control key within a configured interval window
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_tap_control_key_detector
  import dtck_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // key_code[1:0], is_press[2], is_repeat[3], time_ms[35:4], other_key_held[36],
  // mouse_held[37], zero[39:38]
  input  wire logic [39:0]      s_axis_tdata,
  // command[0]
  input  wire logic [0:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // double_tap[0], zero[7:1]
  output logic [7:0]            m_axis_tdata,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t cfg;
  evt_t in_ev;
  evt_t in_ev_next;
  logic in_valid;
  logic out_valid;
  logic out_tap;
  logic advance;
  logic tap;

  assign in_ev_next.command        = s_axis_tuser[0];
  assign in_ev_next.key_code       = s_axis_tdata[1:0];
  assign in_ev_next.is_press       = s_axis_tdata[2];
  assign in_ev_next.is_repeat      = s_axis_tdata[3];
  assign in_ev_next.time_ms        = s_axis_tdata[35:4];
  assign in_ev_next.other_key_held = s_axis_tdata[36];
  assign in_ev_next.mouse_held     = s_axis_tdata[37];

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_tap};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.side_select     <= SIDE_RESET;
      cfg.min_interval_ms <= MIN_RESET;
      cfg.max_interval_ms <= MAX_RESET;
      cfg.cool_period     <= COOLDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIDE:     cfg.side_select     <= cfg_data[1:0];
        REG_MIN:      cfg.min_interval_ms <= cfg_data;
        REG_MAX:      cfg.max_interval_ms <= cfg_data;
        REG_COOLDOWN: cfg.cool_period     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_ev <= in_ev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tap <= tap;
    end
  end

  dtck_core u_core (
    .clk   (clk),
    .rst   (rst),
    .clear (cfg_we),
    .step  (advance),
    .ev    (in_ev),
    .cfg   (cfg),
    .tap   (tap)
  );

endmodule

`default_nettype wire

>>> sim/double_tap_control_key_detector_tb.sv
// ----------------------------------------------------------------------------
// double_tap_control_key_detector_tb
// drives key and mouse events into the detector with random gaps and stalls,
// predicts the double tap flag of every item and checks each result in order;
// runs directed corner events first, then random tap sequences and noise
// under several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_tap_control_key_detector_tb;
  import dtck_pkg::*;

  typedef enum logic [1:0] {TAP_IDLE, TAP_DOWN, TAP_UP, TAP_HELD} tap_phase_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // key_code[1:0], is_press[2], is_repeat[3], time_ms[35:4], other_key_held[36],
  // mouse_held[37], zero[39:38]
  logic [39:0]      s_axis_tdata = '0;
  // command[0]
  logic [0:0]       s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // double_tap[0], zero[7:1]
  logic [7:0]       m_axis_tdata;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_SIDE;
  logic [CFG_W-1:0] cfg_data = '0;

  double_tap_control_key_detector dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predicted detector state and registers
  logic [1:0]           cfg_side = SIDE_RESET;
  logic [CFG_W-1:0]     cfg_min  = MIN_RESET;
  logic [CFG_W-1:0]     cfg_max  = MAX_RESET;
  logic [CFG_W-1:0]     cfg_cool = COOLDOWN_RESET;
  tap_phase_t           tap_phase = TAP_IDLE;
  logic [TIME_BITS-1:0] first_ms = '0;
  logic [TIME_BITS-1:0] cool_end_ms = '0;
  logic [1:0]           cand_key = KEY_OTHER;

  evt_t        pending_events[$];
  logic        expected_taps[$];
  evt_t        held_evt;
  logic        want_tap;
  logic [31:0] now_ms = '0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  bit          src_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  int unsigned err_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void drop_candidate();
    tap_phase = TAP_IDLE;
    first_ms  = '0;
    cand_key  = KEY_OTHER;
  endfunction

  function automatic void start_candidate(input evt_t e);
    tap_phase = TAP_DOWN;
    first_ms  = e.time_ms;
    cand_key  = e.key_code;
  endfunction

  function automatic logic predict_tap(input evt_t e);
    logic [TIME_BITS-1:0] gap;
    logic [TIME_BITS:0]   sum;
    logic                 hit;
    logic                 ok_key;
    hit = 1'b0;
    ok_key = (e.key_code == KEY_LEFT && (cfg_side == SIDE_LEFT || cfg_side == SIDE_EITHER)) ||
             (e.key_code == KEY_RIGHT && (cfg_side == SIDE_RIGHT || cfg_side == SIDE_EITHER));
    if (e.command == CMD_MOUSE || !ok_key) begin
      drop_candidate();
    end else if (!e.is_repeat) begin
      if (e.other_key_held || e.mouse_held || e.time_ms < cool_end_ms) begin
        drop_candidate();
      end else begin
        case (tap_phase)
          TAP_IDLE: begin
            if (e.is_press) start_candidate(e);
          end
          TAP_DOWN: begin
            if (e.key_code != cand_key) drop_candidate();
            else if (!e.is_press) tap_phase = TAP_UP;
          end
          TAP_UP: begin
            if (e.is_press) begin
              gap = e.time_ms - first_ms;
              if (e.key_code == cand_key && gap >= cfg_min && gap <= cfg_max) begin
                sum = {1'b0, e.time_ms} + cfg_cool;
                cool_end_ms = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                tap_phase = TAP_HELD;
                hit = 1'b1;
              end else begin
                start_candidate(e);
              end
            end
          end
          default: begin
            if (e.key_code == cand_key && !e.is_press) tap_phase = TAP_IDLE;
          end
        endcase
      end
    end
    return hit;
  endfunction

  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // register write; the detector clears its tap state on every write
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SIDE: cfg_side = val[1:0];
      REG_MIN:  cfg_min  = val;
      REG_MAX:  cfg_max  = val;
      default:  cfg_cool = val;
    endcase
    drop_candidate();
    cool_end_ms = '0;
  endtask

  task automatic add_evt(input logic cmd, input logic [1:0] key, input logic press,
                         input logic rep, input logic [31:0] t, input logic oth,
                         input logic mou);
    evt_t e;
    e.command        = cmd;
    e.key_code       = key;
    e.is_press       = press;
    e.is_repeat      = rep;
    e.time_ms        = t;
    e.other_key_held = oth;
    e.mouse_held     = mou;
    pending_events.push_back(e);
  endtask

  task automatic tap(input logic [1:0] key, input logic press, input logic [31:0] t);
    add_evt(CMD_KEY, key, press, 1'b0, t, 1'b0, 1'b0);
  endtask

  task automatic add_random_evt(input logic cmd, input logic [1:0] key, input logic press,
                                input int unsigned dt);
    now_ms += dt;
    add_evt(cmd, key, press, chance(4), now_ms, chance(3), chance(3));
  endtask

  function automatic logic [1:0] pick_tap_key();
    if (chance(10)) return 2'($urandom_range(0, 3));
    case (cfg_side)
      SIDE_LEFT:  return KEY_LEFT;
      SIDE_RIGHT: return KEY_RIGHT;
      default:    return chance(50) ? KEY_LEFT : KEY_RIGHT;
    endcase
  endfunction

  task automatic fill_random(input int unsigned n_items);
    int unsigned added;
    int unsigned r;
    int unsigned g;
    int unsigned a;
    logic [1:0]  key;
    logic [1:0]  second;
    added = 0;
    while (added < n_items) begin
      r = $urandom_range(0, 99);
      key = pick_tap_key();
      if (r < 65) begin
        // press, release, press, release with the interval at or beside the window edges, inside it or random
        case ($urandom_range(0, 5))
          0: g = cfg_min;
          1: g = cfg_max;
          2: g = (cfg_min == 0) ? 0 : int'(cfg_min) - 1;
          3: g = int'(cfg_max) + 1;
          4: g = $urandom_range(cfg_min, cfg_max);
          default: g = $urandom_range(0, 1000);
        endcase
        a = $urandom_range(0, g);
        second = chance(10) ? key ^ 2'b11 : key;
        add_random_evt(CMD_KEY, key, 1'b1, $urandom_range(0, 2 * int'(cfg_cool) + 100));
        add_random_evt(CMD_KEY, key, 1'b0, a);
        add_random_evt(CMD_KEY, second, 1'b1, g - a);
        add_random_evt(CMD_KEY, second, 1'b0, $urandom_range(0, 300));
        added += 4;
      end else if (r < 85) begin
        add_random_evt(chance(15) ? CMD_MOUSE : CMD_KEY, 2'($urandom_range(0, 3)),
                       1'($urandom_range(0, 1)), $urandom_range(0, 600));
        added++;
      end else begin
        // tap broken by a mouse event or another key
        add_random_evt(CMD_KEY, key, 1'b1, $urandom_range(0, 2 * int'(cfg_cool) + 100));
        if (chance(50)) add_random_evt(CMD_MOUSE, 2'($urandom_range(0, 3)),
                                       1'($urandom_range(0, 1)), $urandom_range(0, 100));
        else add_random_evt(CMD_KEY, KEY_OTHER, 1'b1, $urandom_range(0, 100));
        add_random_evt(CMD_KEY, key, 1'b0, $urandom_range(0, 100));
        added += 3;
      end
    end
  endtask

  task automatic drain();
    while (pending_events.size() != 0 || s_axis_tvalid || expected_taps.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // event driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_taps.push_back(predict_tap(held_evt));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          held_evt = pending_events.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, held_evt.mouse_held, held_evt.other_key_held,
                            held_evt.time_ms, held_evt.is_repeat, held_evt.is_press,
                            held_evt.key_code};
          s_axis_tuser  <= held_evt.command;
          if ($urandom_range(0, 149) == 0) src_quiet = !src_quiet;
          src_gap = pick_gap(src_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_taps.size() == 0) begin
          note_mismatch($sformatf("unexpected item: double_tap %b", m_axis_tdata[0]));
        end else begin
          want_tap = expected_taps.pop_front();
          if (m_axis_tdata[0] !== want_tap)
            note_mismatch($sformatf("double_tap mismatch: expected %b actual %b",
                                    want_tap, m_axis_tdata[0]));
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 149) == 0) sink_quiet = !sink_quiet;
        sink_gap = pick_gap(sink_quiet);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // interval wrapping across the top of the time range
    tap(KEY_LEFT, 1'b1, 32'hFFFF_FF00);
    tap(KEY_LEFT, 1'b0, 32'hFFFF_FF80);
    tap(KEY_LEFT, 1'b1, 32'h0000_0010);
    tap(KEY_LEFT, 1'b0, 32'h0000_0020);
    // minimum interval, autorepeat ignored, release after cooldown
    tap(KEY_LEFT, 1'b1, 32'd1000);
    tap(KEY_LEFT, 1'b0, 32'd1020);
    tap(KEY_LEFT, 1'b1, 32'd1050);
    add_evt(CMD_KEY, KEY_LEFT, 1'b1, 1'b1, 32'd1060, 1'b0, 1'b0);
    tap(KEY_LEFT, 1'b0, 32'd1600);
    // maximum interval on the right key
    tap(KEY_RIGHT, 1'b1, 32'd2000);
    tap(KEY_RIGHT, 1'b0, 32'd2100);
    tap(KEY_RIGHT, 1'b1, 32'd2400);
    tap(KEY_RIGHT, 1'b0, 32'd2950);
    // one past the maximum, then too short
    tap(KEY_LEFT, 1'b1, 32'd3000);
    tap(KEY_LEFT, 1'b0, 32'd3010);
    tap(KEY_LEFT, 1'b1, 32'd3401);
    tap(KEY_LEFT, 1'b0, 32'd3420);
    tap(KEY_LEFT, 1'b1, 32'd3440);
    // cancels: other key, unused key code, mouse event, held keys and buttons
    tap(KEY_OTHER, 1'b1, 32'd3500);
    tap(2'd3, 1'b1, 32'd3510);
    add_evt(CMD_MOUSE, KEY_RIGHT, 1'b1, 1'b1, 32'd3520, 1'b1, 1'b1);
    add_evt(CMD_KEY, KEY_LEFT, 1'b1, 1'b0, 32'd3530, 1'b1, 1'b0);
    add_evt(CMD_KEY, KEY_LEFT, 1'b1, 1'b0, 32'd3540, 1'b0, 1'b1);
    // cooldown end saturates at the top of the time range
    tap(KEY_LEFT, 1'b1, 32'hFFFF_FE00);
    tap(KEY_LEFT, 1'b0, 32'hFFFF_FE10);
    tap(KEY_LEFT, 1'b1, 32'hFFFF_FF00);
    tap(KEY_LEFT, 1'b1, 32'hFFFF_FFFF);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          write_reg(REG_SIDE, SIDE_LEFT);
          write_reg(REG_MIN, 16'd0);
          write_reg(REG_MAX, 16'hFFFF);
          write_reg(REG_COOLDOWN, 16'd0);
        end
        1: begin
          write_reg(REG_COOLDOWN, 16'hFFFF);
          write_reg(REG_SIDE, SIDE_RIGHT);
          write_reg(REG_MIN, 16'hFFFF);
          write_reg(REG_MAX, 16'hFFFF);
        end
        2: begin
          write_reg(REG_SIDE, 2'd3);
          write_reg(REG_MIN, 16'd10);
          write_reg(REG_MAX, 16'd100);
          write_reg(REG_COOLDOWN, 16'd20);
        end
        3: begin
          // minimum above maximum
          write_reg(REG_SIDE, SIDE_EITHER);
          write_reg(REG_MIN, 16'd300);
          write_reg(REG_MAX, 16'd100);
          write_reg(REG_COOLDOWN, 16'd50);
        end
        default: begin
          write_reg(REG_SIDE, 16'($urandom_range(0, 2)));
          write_reg(REG_MIN, 16'($urandom_range(0, 200)));
          write_reg(REG_MAX, 16'($urandom_range(150, 600)));
          write_reg(REG_COOLDOWN, 16'($urandom_range(0, 1000)));
        end
      endcase
      @(negedge clk);
      now_ms = chance(20) ? 32'hFFFF_FFFF - $urandom_range(0, 200000) : $urandom;
      fill_random(100);
      drain();
    end

    repeat (8) @(negedge clk);
    if (err_count == 0 && expected_taps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
